// File: rtl/core/slc_pkg.sv
// Shared constants, types and helpers for the source line classifier.
package slc_pkg;

  localparam int COUNT_WIDTH = 32;
  localparam int OUT_WIDTH   = 32;

  localparam logic [7:0] CH_TAB     = 8'd9;
  localparam logic [7:0] CH_NEWLINE = 8'd10;
  localparam logic [7:0] CH_CR      = 8'd13;
  localparam logic [7:0] CH_SPACE   = 8'd32;
  localparam logic [7:0] CH_STAR    = 8'd42;
  localparam logic [7:0] CH_SLASH   = 8'd47;
  localparam logic [7:0] CH_SEMI    = 8'd59;

  typedef enum logic [1:0] {
    ST_UNDECIDED = 2'd0,
    ST_COMMENT   = 2'd1,
    ST_CODE      = 2'd2
  } line_status_t;

  typedef enum logic [1:0] {
    CLS_CODE    = 2'd0,
    CLS_COMMENT = 2'd1,
    CLS_BLANK   = 2'd2
  } line_class_t;

  typedef struct packed {
    logic is_comment;
    logic only_spaces;
    logic comment_open;
  } line_evt_t;

  function automatic logic is_ws(input logic [7:0] b);
    return (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
  endfunction

endpackage

// File: rtl/core/source_line_classifier.sv
// Source line classifier top level: input register, scanner, result register.
// Usage:
//   Bytes of source text enter on in_valid / in_stall / char_byte; an item is
//   taken on a clock edge with in_valid high and in_stall low. Each newline
//   yields one result on out_valid / out_stall: line_class, the three
//   saturating counts and comment_open. Other bytes yield no result.
//   asm_mode is written through cfg_valid / cfg_ready (ready always high) and
//   should only change while the block is idle.
// Timing:
//   One byte per cycle sustained, unless a newline waits on a held result (see
//   Stalls). Each byte is captured in the input register; the scanner state
//   and, for a newline, the result register update as it leaves that register.
//   The rate is set by the scanner state loop.
// Stalls:
//   While out_stall holds a result, non-newline bytes keep flowing; a newline
//   waits in the input register and in_stall rises until the result is taken.
// Reset:
//   rst (synchronous) clears the counts, the comment state, asm_mode and all
//   valid flags.
module source_line_classifier (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic                          asm_mode,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [7:0]                    char_byte,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [1:0]                    line_class,
  output logic [slc_pkg::OUT_WIDTH-1:0] lines_seen,
  output logic [slc_pkg::OUT_WIDTH-1:0] comments_seen,
  output logic [slc_pkg::OUT_WIDTH-1:0] blanks_seen,
  output logic                          comment_open
);

  logic               mode_asm;
  logic               s1_valid;
  logic [7:0]         s1_byte;
  logic               s1_newline;
  logic               s1_fire;
  logic               out_free;
  logic               in_take;
  slc_pkg::line_evt_t evt;

  assign cfg_ready  = 1'b1;
  assign s1_newline = (s1_byte == slc_pkg::CH_NEWLINE);
  assign out_free   = !out_valid || !out_stall;
  assign s1_fire    = s1_valid && (!s1_newline || out_free);
  assign in_stall   = s1_valid && !s1_fire;
  assign in_take    = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_asm <= 1'b0;
    end else if (cfg_valid) begin
      mode_asm <= asm_mode;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_take) begin
        s1_valid <= 1'b1;
      end else if (s1_fire) begin
        s1_valid <= 1'b0;
      end
      if (s1_fire && s1_newline) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) s1_byte <= char_byte;
  end

  slc_scan u_scan (
    .clk       (clk),
    .rst       (rst),
    .fire      (s1_fire),
    .asm_mode  (mode_asm),
    .char_byte (s1_byte),
    .evt       (evt)
  );

  slc_result u_result (
    .clk           (clk),
    .rst           (rst),
    .load          (s1_fire && s1_newline),
    .evt           (evt),
    .line_class    (line_class),
    .lines_seen    (lines_seen),
    .comments_seen (comments_seen),
    .blanks_seen   (blanks_seen),
    .comment_open  (comment_open)
  );

  a_stall_needs_item: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (s1_valid && s1_newline && out_valid && out_stall))
    else $error("input stalled without a blocked newline");

  a_newline_gives_result: assert property (@(posedge clk) disable iff (rst)
    (s1_fire && s1_newline) |=> out_valid)
    else $error("newline item gave no result");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |-> !(s1_fire && s1_newline))
    else $error("held result overwritten");

endmodule

// File: rtl/core/slc_scan.sv
// Per-line scanner: comment and blank tracking state, updated once per item.
module slc_scan (
  input  logic                clk,
  input  logic                rst,
  input  logic                fire,
  input  logic                asm_mode,
  input  logic [7:0]          char_byte,
  output slc_pkg::line_evt_t  evt
);

  logic                  in_comment, in_comment_next;
  slc_pkg::line_status_t line_status, line_status_next;
  logic                  slash_pending, slash_pending_next;
  logic                  star_pending, star_pending_next;
  logic                  only_spaces, only_spaces_next;
  logic                  is_newline;

  assign is_newline = (char_byte == slc_pkg::CH_NEWLINE);

  always_comb begin
    in_comment_next    = in_comment;
    line_status_next   = line_status;
    slash_pending_next = slash_pending;
    star_pending_next  = star_pending;
    only_spaces_next   = only_spaces;
    if (is_newline) begin
      line_status_next   = slc_pkg::ST_UNDECIDED;
      slash_pending_next = 1'b0;
      star_pending_next  = 1'b0;
      only_spaces_next   = 1'b1;
    end else begin
      if (char_byte != slc_pkg::CH_SPACE) only_spaces_next = 1'b0;
      if (asm_mode) begin
        slash_pending_next = 1'b0;
        star_pending_next  = 1'b0;
        if (line_status == slc_pkg::ST_UNDECIDED) begin
          if (char_byte == slc_pkg::CH_SEMI) begin
            line_status_next = slc_pkg::ST_COMMENT;
          end else if (!slc_pkg::is_ws(char_byte)) begin
            line_status_next = slc_pkg::ST_CODE;
          end
        end
      end else if ((line_status == slc_pkg::ST_COMMENT) ||
                   ((line_status == slc_pkg::ST_UNDECIDED) && in_comment)) begin
        line_status_next   = slc_pkg::ST_COMMENT;
        slash_pending_next = 1'b0;
        if (in_comment) begin
          if (star_pending && (char_byte == slc_pkg::CH_SLASH)) begin
            in_comment_next   = 1'b0;
            star_pending_next = 1'b0;
          end else begin
            star_pending_next = (char_byte == slc_pkg::CH_STAR);
          end
        end else begin
          star_pending_next = 1'b0;
        end
      end else if (line_status == slc_pkg::ST_UNDECIDED) begin
        if (slash_pending) begin
          slash_pending_next = 1'b0;
          if (char_byte == slc_pkg::CH_STAR) begin
            in_comment_next   = 1'b1;
            line_status_next  = slc_pkg::ST_COMMENT;
            star_pending_next = 1'b1;
          end else begin
            line_status_next = slc_pkg::ST_CODE;
          end
        end else if (char_byte == slc_pkg::CH_SLASH) begin
          slash_pending_next = 1'b1;
        end else if (!slc_pkg::is_ws(char_byte)) begin
          line_status_next = slc_pkg::ST_CODE;
        end
      end
    end
  end

  // opener seen only as a lone slash does not count
  always_comb begin
    if (asm_mode) begin
      evt.is_comment = (line_status == slc_pkg::ST_COMMENT);
    end else begin
      evt.is_comment = (line_status == slc_pkg::ST_COMMENT) ||
                       ((line_status == slc_pkg::ST_UNDECIDED) && !slash_pending &&
                        in_comment);
    end
    evt.only_spaces  = only_spaces;
    evt.comment_open = in_comment;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_comment    <= 1'b0;
      line_status   <= slc_pkg::ST_UNDECIDED;
      slash_pending <= 1'b0;
      star_pending  <= 1'b0;
      only_spaces   <= 1'b1;
    end else if (fire) begin
      in_comment    <= in_comment_next;
      line_status   <= line_status_next;
      slash_pending <= slash_pending_next;
      star_pending  <= star_pending_next;
      only_spaces   <= only_spaces_next;
    end
  end

  a_newline_clears: assert property (@(posedge clk) disable iff (rst)
    (fire && is_newline) |=>
      (line_status == slc_pkg::ST_UNDECIDED) && only_spaces && !slash_pending &&
      !star_pending)
    else $error("line state not cleared after newline");

  a_pending_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(slash_pending && star_pending))
    else $error("slash and star pending together");

  a_asm_keeps_comment: assert property (@(posedge clk) disable iff (rst)
    (fire && asm_mode) |=> (in_comment == $past(in_comment)))
    else $error("assembler item changed block comment state");

endmodule

// File: rtl/core/slc_result.sv
// Result register: line class, open-comment flag and saturating line counts.
module slc_result (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          load,
  input  slc_pkg::line_evt_t            evt,
  output logic [1:0]                    line_class,
  output logic [slc_pkg::OUT_WIDTH-1:0] lines_seen,
  output logic [slc_pkg::OUT_WIDTH-1:0] comments_seen,
  output logic [slc_pkg::OUT_WIDTH-1:0] blanks_seen,
  output logic                          comment_open
);

  localparam logic [slc_pkg::COUNT_WIDTH-1:0] COUNT_MAX = '1;

  slc_pkg::line_class_t             cls, cls_next;
  logic                             open_flag;
  logic [slc_pkg::COUNT_WIDTH-1:0]  total_cnt, total_cnt_next;
  logic [slc_pkg::COUNT_WIDTH-1:0]  comment_cnt, comment_cnt_next;
  logic [slc_pkg::COUNT_WIDTH-1:0]  blank_cnt, blank_cnt_next;

  always_comb begin
    comment_cnt_next = comment_cnt;
    blank_cnt_next   = blank_cnt;
    if (evt.is_comment) begin
      cls_next = slc_pkg::CLS_COMMENT;
      if (comment_cnt != COUNT_MAX) comment_cnt_next = comment_cnt + 1'b1;
    end else if (evt.only_spaces) begin
      cls_next = slc_pkg::CLS_BLANK;
      if (blank_cnt != COUNT_MAX) blank_cnt_next = blank_cnt + 1'b1;
    end else begin
      cls_next = slc_pkg::CLS_CODE;
    end
    total_cnt_next = (total_cnt != COUNT_MAX) ? total_cnt + 1'b1 : total_cnt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      total_cnt   <= '0;
      comment_cnt <= '0;
      blank_cnt   <= '0;
    end else if (load) begin
      total_cnt   <= total_cnt_next;
      comment_cnt <= comment_cnt_next;
      blank_cnt   <= blank_cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cls       <= cls_next;
      open_flag <= evt.comment_open;
    end
  end

  assign line_class   = cls;
  assign comment_open = open_flag;

  generate
    if (slc_pkg::COUNT_WIDTH >= slc_pkg::OUT_WIDTH) begin : g_trunc
      assign lines_seen    = total_cnt[slc_pkg::OUT_WIDTH-1:0];
      assign comments_seen = comment_cnt[slc_pkg::OUT_WIDTH-1:0];
      assign blanks_seen   = blank_cnt[slc_pkg::OUT_WIDTH-1:0];
    end else begin : g_ext
      assign lines_seen    = {{(slc_pkg::OUT_WIDTH-slc_pkg::COUNT_WIDTH){1'b0}}, total_cnt};
      assign comments_seen = {{(slc_pkg::OUT_WIDTH-slc_pkg::COUNT_WIDTH){1'b0}}, comment_cnt};
      assign blanks_seen   = {{(slc_pkg::OUT_WIDTH-slc_pkg::COUNT_WIDTH){1'b0}}, blank_cnt};
    end
  endgenerate

  a_counts_bounded: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, comment_cnt} + {1'b0, blank_cnt}) <= {1'b0, total_cnt})
    else $error("comment plus blank count exceeds total");

  a_total_moves: assert property (@(posedge clk) disable iff (rst)
    load |=> (total_cnt != '0))
    else $error("total count zero after a line");

  a_counts_hold: assert property (@(posedge clk) disable iff (rst)
    !load |=> $stable(total_cnt) && $stable(comment_cnt) && $stable(blank_cnt))
    else $error("counts changed without a line");

endmodule
